>>> sv/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants, codes and types for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int LIST_DEPTH  = 16;
  localparam int LIST_DW     = 32;
  localparam int MAX_RESULTS = 16;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  localparam logic [STAT_W-1:0] STS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STS_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STS_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] STS_NOMATCH = 2'd3;

  // per-cell control, driven by the sequencer each cycle
  typedef struct packed {
    logic load;        // take the incoming value
    logic shift_up;    // take the neighbour below
    logic shift_down;  // take the neighbour above
    logic active;      // cell holds a live entry
    logic hit_load;    // capture compare result
    logic hit_clr;     // drop hit flag once reported
  } cell_ctl_t;

endpackage

>>> sv/sle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: data word, neighbour shifting and a search hit flag.
// ----------------------------------------------------------------------------
module sle_cell #(
  parameter int DATA_WIDTH = sle_pkg::LIST_DW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sle_pkg::cell_ctl_t    ctl_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] below_i,
  input  logic [DATA_WIDTH-1:0] above_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  match_o,
  output logic                  hit_o
);
  import sle_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic                  hit_r;

  // raw compare; the sequencer masks it with the live-entry flags
  assign match_o = (data_r == value_i);
  assign data_o  = data_r;
  assign hit_o   = hit_r;

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      data_r <= value_i;
    end else if (ctl_i.shift_up) begin
      data_r <= below_i;
    end else if (ctl_i.shift_down) begin
      data_r <= above_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl_i.hit_load) begin
      hit_r <= match_o && ctl_i.active;
    end else if (ctl_i.hit_clr) begin
      hit_r <= 1'b0;
    end
  end

endmodule

>>> sv/sequential_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of values held in a shifting row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command per transfer:
//   append, insert, delete, find, read or clear. Result channel
//   (out_valid/out_stall) returns the results, final one flagged by out_last.
//   cfg_wr_en/cfg_wr_data set the capacity; write it only while idle.
// Command flow:
//   Append, insert and delete update their cells at once in the accepting
//   cycle; read and clear also finish in it. Their single result is registered
//   and appears in the cycle after. One such command per cycle while the
//   result side keeps up. Find compares all cells in the accepting cycle,
//   then reports one match per cycle while the receiver keeps up, from the
//   registered hit flags (lowest position first); in_stall stays high
//   meanwhile. No match gives one result, registered in the cycle after.
// Reset: list empty, capacity 16, no result pending. Cell data is not reset.
// Receiver stall: the output register holds its result; in_stall rises
//   until the result is taken, and a running search pauses.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
  parameter int DEPTH      = sle_pkg::LIST_DEPTH,
  parameter int DATA_WIDTH = sle_pkg::LIST_DW
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sle_pkg::CMD_W-1:0]          in_command,
  input  logic [sle_pkg::POS_W-1:0]          in_position,
  input  logic signed [sle_pkg::VAL_W-1:0]   in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sle_pkg::STAT_W-1:0]         out_status,
  output logic [sle_pkg::POS_W-1:0]          out_found_position,
  output logic signed [sle_pkg::VAL_W-1:0]   out_read_value,
  output logic [sle_pkg::POS_W-1:0]          out_length,
  output logic                               out_last,
  input  logic                               cfg_wr_en,
  input  logic [sle_pkg::CAP_W-1:0]          cfg_wr_data
);
  import sle_pkg::*;

  // count width, and a compare width with headroom for pos, count and +1
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW + 1 : POS_W + 1;
  localparam int RW = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SRCH = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CAP_W-1:0]       cap_r;
  logic [RW-1:0]          sent_r, sent_nxt;

  logic                   out_valid_r;
  logic [STAT_W-1:0]      out_status_r;
  logic [POS_W-1:0]       out_pos_r;
  logic [VAL_W-1:0]       out_rdv_r;
  logic [POS_W-1:0]       out_len_r;
  logic                   out_last_r;

  cell_ctl_t              ctl    [DEPTH];
  logic [DATA_WIDTH-1:0]  cdata  [DEPTH];
  logic [DEPTH-1:0]       match_w;
  logic [DEPTH-1:0]       act_w;
  logic [DEPTH-1:0]       hit_w;
  logic [DEPTH-1:0]       grant;
  logic [DEPTH-1:0]       rest;

  logic [63:0]            val_pad;
  logic [DATA_WIDTH-1:0]  key;
  logic [DATA_WIDTH-1:0]  rd_data;
  logic [63:0]            rd_pad;
  logic [XW-1:0]          pos_x, cnt_x, lim_x, grant_pos;
  logic                   slot_free, acc, full;
  logic                   ins_ok, del_ok;
  logic                   emit;
  logic [STAT_W-1:0]      e_status;
  logic [POS_W-1:0]       e_pos;
  logic [VAL_W-1:0]       e_rdv;
  logic                   e_last;

  // value trimmed or zero-extended to the cell width
  assign val_pad = {32'b0, in_value};
  assign key     = val_pad[DATA_WIDTH-1:0];

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && slot_free);
  assign acc       = in_valid && !in_stall;

  assign pos_x  = XW'(in_position);
  assign cnt_x  = XW'(count_r);
  assign lim_x  = (XW'(cap_r) < XW'(DEPTH)) ? XW'(cap_r) : XW'(DEPTH);
  assign full   = cnt_x >= lim_x;
  assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
  assign del_ok = (pos_x != '0) && (pos_x <= cnt_x);

  // live entries sit below the count
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      act_w[i] = XW'(i) < cnt_x;
    end
  end

  // read mux over the row
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (XW'(i) == pos_x - XW'(1)) rd_data = cdata[i];
    end
  end
  assign rd_pad = 64'(rd_data);

  // lowest pending hit, and what stays after it
  assign grant = hit_w & (~hit_w + DEPTH'(1));
  assign rest  = hit_w & ~grant;
  always_comb begin
    grant_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (grant[i]) grant_pos = grant_pos | XW'(i + 1);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    sent_nxt  = sent_r;
    emit      = 1'b0;
    e_status  = STS_OK;
    e_pos     = '0;
    e_rdv     = '0;
    e_last    = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i]        = '0;
      ctl[i].active = act_w[i];
    end

    if (acc) begin
      emit = 1'b1;
      unique case (in_command)
        CMD_APPEND: begin
          if (full) begin
            e_status = STS_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              ctl[i].load = (XW'(i) == cnt_x);
            end
            count_nxt = CW'(cnt_x + XW'(1));
          end
        end
        CMD_INSERT: begin
          if (!ins_ok) begin
            e_status = STS_RANGE;
          end else if (full) begin
            e_status = STS_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              ctl[i].load     = (XW'(i) == pos_x - XW'(1));
              ctl[i].shift_up = (XW'(i) >= pos_x);
            end
            count_nxt = CW'(cnt_x + XW'(1));
          end
        end
        CMD_DELETE: begin
          if (!del_ok) begin
            e_status = STS_RANGE;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              ctl[i].shift_down = (XW'(i) >= pos_x - XW'(1));
            end
            count_nxt = CW'(cnt_x - XW'(1));
          end
        end
        CMD_FIND: begin
          for (int i = 0; i < DEPTH; i++) begin
            ctl[i].hit_load = 1'b1;
          end
          if (|(match_w & act_w)) begin
            emit      = 1'b0;
            sent_nxt  = '0;
            state_nxt = ST_SRCH;
          end else begin
            e_status = STS_NOMATCH;
          end
        end
        CMD_READ: begin
          if (!del_ok) begin
            e_status = STS_RANGE;
          end else begin
            e_rdv = rd_pad[VAL_W-1:0];
          end
        end
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if ((state_r == ST_SRCH) && slot_free) begin
      emit   = 1'b1;
      e_pos  = POS_W'(grant_pos);
      e_last = (rest == '0) || (sent_r == RW'(MAX_RESULTS - 1));
      sent_nxt = RW'(sent_r + RW'(1));
      for (int i = 0; i < DEPTH; i++) begin
        ctl[i].hit_clr = e_last || grant[i];
      end
      if (e_last) state_nxt = ST_IDLE;
    end
  end

  // the row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] below, above;
    if (g == 0) begin : g_lo
      assign below = '0;
    end else begin : g_lo
      assign below = cdata[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign above = '0;
    end else begin : g_hi
      assign above = cdata[g+1];
    end
    sle_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl[g]),
      .value_i (key),
      .below_i (below),
      .above_i (above),
      .data_o  (cdata[g]),
      .match_o (match_w[g]),
      .hit_o   (hit_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      sent_r  <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sent_r  <= sent_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= e_status;
      out_pos_r    <= e_pos;
      out_rdv_r    <= e_rdv;
      out_len_r    <= POS_W'(count_nxt);
      out_last_r   <= e_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_pos_r;
  assign out_read_value     = signed'(out_rdv_r);
  assign out_length         = out_len_r;
  assign out_last           = out_last_r;

endmodule
